// ===== rtl/core/vau_pkg.sv =====
// shared constants, types and the exp table for the vector activation unit
package vau_pkg;

    localparam int MAX_LEN        = 64;
    localparam int EXP_TABLE_BITS = 8;
    localparam int ADDR_W         = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int CNT_W          = $clog2(MAX_LEN + 1);
    localparam int EXP_SHIFT      = 24 - EXP_TABLE_BITS;
    localparam int EXP_ENTRIES    = 2 ** EXP_TABLE_BITS;

    localparam int NUM_W = 33;
    localparam int DEN_W = 32;
    localparam int QUO_W = 17;

    localparam logic [16:0] LOG2E_Q16 = 17'd94548;
    localparam logic [16:0] ONE_Q16   = 17'd65536;
    localparam logic [16:0] HALF_Q16  = 17'd32768;

    localparam logic [1:0] FN_RELU    = 2'd0;
    localparam logic [1:0] FN_SIGMOID = 2'd1;
    localparam logic [1:0] FN_SOFTMAX = 2'd2;
    localparam logic [1:0] FN_RSVD    = 2'd3;

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } t_div_req;

    typedef logic [16:0] t_exp_table [EXP_ENTRIES];

    function automatic logic [63:0] isqrt64(input logic [63:0] n_in);
        logic [63:0] n;
        logic [63:0] r;
        logic [63:0] b;
        n = n_in;
        r = '0;
        b = 64'd1 << 62;
        for (int i = 0; i < 32; i++) begin
            if (b > n) b = b >> 2;
        end
        for (int i = 0; i < 32; i++) begin
            if (b != 0) begin
                if (n >= r + b) begin
                    n = n - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
        end
        return r;
    endfunction

    // 2^(-k/2^EXP_TABLE_BITS) in q1.16, built from repeated square roots of one half
    function automatic t_exp_table build_exp_table();
        t_exp_table  tbl;
        logic [63:0] roots [EXP_TABLE_BITS+1];
        logic [63:0] p;
        roots[0] = 64'd1 << 30;
        roots[1] = isqrt64((64'd1 << 29) << 30);
        for (int j = 2; j <= EXP_TABLE_BITS; j++) begin
            roots[j] = isqrt64(roots[j-1] << 30);
        end
        for (int k = 0; k < EXP_ENTRIES; k++) begin
            p = 64'd1 << 30;
            for (int i = 0; i < EXP_TABLE_BITS; i++) begin
                if (((k >> i) & 1) != 0) begin
                    p = (p * roots[EXP_TABLE_BITS-i] + (64'd1 << 29)) >> 30;
                end
            end
            tbl[k] = 17'((p + (64'd1 << 13)) >> 14);
        end
        return tbl;
    endfunction

    localparam t_exp_table EXP_TABLE = build_exp_table();

endpackage

// ===== rtl/core/vau_div.sv =====
// restoring divider, one quotient bit per cycle
module vau_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  vau_pkg::t_div_req i_req,
    output logic              o_done,
    output logic [vau_pkg::QUO_W-1:0] o_quo
);
    import vau_pkg::*;

    localparam int CW = $clog2(QUO_W + 1);

    logic             r_busy;
    logic [CW-1:0]    r_cnt;
    logic [DEN_W-1:0] r_rem;
    logic [QUO_W-1:0] r_lo;
    logic [DEN_W-1:0] r_den;
    logic [QUO_W-1:0] r_quo;
    logic             r_done;
    logic [DEN_W:0]   w_trial;
    logic             w_ge;

    assign w_trial = {r_rem, r_lo[QUO_W-1]};
    assign w_ge    = (w_trial >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(QUO_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            // quotient fits QUO_W bits, so the upper part is already below the divisor
            r_rem <= DEN_W'(i_req.num >> QUO_W);
            r_lo  <= i_req.num[QUO_W-1:0];
            r_den <= i_req.den;
            r_quo <= '0;
        end else if (r_busy) begin
            r_rem <= w_ge ? DEN_W'(w_trial - {1'b0, r_den}) : w_trial[DEN_W-1:0];
            r_lo  <= {r_lo[QUO_W-2:0], 1'b0};
            r_quo <= {r_quo[QUO_W-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

// ===== rtl/core/vector_activation_unit.sv =====
// vector activation unit top level: element store, exp, divide and emit sequencer
//
// input channel (i_valid/o_ready) takes one element per cycle while loading;
// func and derivative of the first element of a vector govern the whole vector.
// elements past the store depth are dropped; an element with last set closes
// the vector even if dropped.
// after the last element the unit stops taking input and emits one item per
// stored element on o_valid/i_ready, in arrival order, end_of_vector on the last.
// per element: relu reads, selects and emits; sigmoid adds a divide, and the
// derivative one more step; softmax first sweeps the store to sum exp, then
// reads, takes exp and divides per element, paced by the bit-serial divider
// and the single-port store read. a stalled receiver holds the sequencer in its
// output wait; the output register frees the unit as soon as the item is taken.
// reset clears the counters and maximum; the store needs no clearing since
// only entries written in the current vector are read.
module vector_activation_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_func,
    input  logic        i_derivative,
    input  logic signed [15:0] i_value,
    input  logic        i_last,
    output logic        o_valid,
    input  logic        i_ready,
    output logic signed [31:0] o_result,
    output logic        o_error,
    output logic        o_end_of_vector
);
    import vau_pkg::*;

    localparam logic [2:0] ST_LOAD = 3'd0;
    localparam logic [2:0] ST_RD   = 3'd1;
    localparam logic [2:0] ST_X    = 3'd2;
    localparam logic [2:0] ST_MUL  = 3'd3;
    localparam logic [2:0] ST_EXP  = 3'd4;
    localparam logic [2:0] ST_DIV  = 3'd5;
    localparam logic [2:0] ST_DER  = 3'd6;
    localparam logic [2:0] ST_OUT  = 3'd7;

    localparam int Y_W = 34 - EXP_SHIFT;

    logic signed [15:0] r_mem [MAX_LEN];
    logic signed [15:0] r_rdata;

    logic [2:0]         r_state;
    logic               r_pass_emit;
    logic [CNT_W-1:0]   r_idx;
    logic [CNT_W-1:0]   r_count;
    logic signed [15:0] r_max;
    logic [31:0]        r_sum;
    logic [2:0]         r_mode;
    logic [32:0]        r_prod;
    logic [16:0]        r_s;
    logic [31:0]        r_res;
    logic               r_err;
    logic               r_ovalid;
    logic [31:0]        r_oresult;
    logic               r_oerr;
    logic               r_oeov;

    logic               w_in_acc;
    logic               w_emit;
    logic [1:0]         w_func;
    logic [1:0]         w_mfunc;
    logic               w_mder;
    logic               w_lastidx;
    logic [16:0]        w_diff;
    logic [Y_W-1:0]     w_y;
    logic [Y_W-EXP_TABLE_BITS-1:0] w_n;
    logic [16:0]        w_e;
    logic [16:0]        w_xe;
    logic [16:0]        w_mag;
    logic [16:0]        w_sden;
    logic [33:0]        w_der_p;
    logic [16:0]        w_s;
    logic               w_quo_done;
    logic [QUO_W-1:0]   w_quo;
    t_div_req           n_div;

    assign o_ready   = (r_state == ST_LOAD);
    assign w_in_acc  = i_valid && o_ready;
    assign w_emit    = (r_state == ST_OUT) && (!r_ovalid || i_ready);
    assign w_func    = (r_count == '0) ? i_func : r_mode[1:0];
    assign w_mfunc   = r_mode[1:0];
    assign w_mder    = r_mode[2];
    assign w_lastidx = (r_idx + 1'b1 == r_count);

    // exp of (max - x) through log2 units, table lookup and shift
    assign w_diff = 17'({r_max[15], r_max} - {r_rdata[15], r_rdata});
    assign w_y    = Y_W'((34'(r_prod) + (34'd1 << (EXP_SHIFT - 1))) >> EXP_SHIFT);
    assign w_n    = w_y[Y_W-1:EXP_TABLE_BITS];
    assign w_e    = (w_n >= 32) ? 17'd0 : (EXP_TABLE[w_y[EXP_TABLE_BITS-1:0]] >> w_n[4:0]);

    assign w_xe   = {r_rdata[15], r_rdata};
    assign w_mag  = r_rdata[15] ? (~w_xe + 17'd1) : w_xe;
    assign w_sden = 17'd256 + w_mag;

    assign w_der_p = 34'(r_s) * 34'(ONE_Q16 - r_s);

    always_comb begin
        if (w_mfunc == FN_SIGMOID) begin
            w_s = r_rdata[15] ? (HALF_Q16 - w_quo) : (HALF_Q16 + w_quo);
        end else begin
            w_s = (r_sum == '0) ? 17'd0 : w_quo;
        end
    end

    always_comb begin
        n_div.start = 1'b0;
        n_div.num   = NUM_W'({w_mag, 15'd0}) + NUM_W'(w_sden >> 1);
        n_div.den   = DEN_W'(w_sden);
        if (r_state == ST_X && w_mfunc == FN_SIGMOID) begin
            n_div.start = 1'b1;
        end else if (r_state == ST_EXP && r_pass_emit) begin
            n_div.start = 1'b1;
            n_div.num   = NUM_W'({w_e, 16'd0}) + NUM_W'(r_sum >> 1);
            n_div.den   = r_sum;
        end
    end

    vau_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (n_div),
        .o_done  (w_quo_done),
        .o_quo   (w_quo)
    );

    // element store
    always_ff @(posedge i_clk) begin
        if (w_in_acc && r_count < CNT_W'(MAX_LEN)) begin
            r_mem[r_count[ADDR_W-1:0]] <= i_value;
        end
        r_rdata <= r_mem[r_idx[ADDR_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_LOAD;
            r_pass_emit <= 1'b0;
            r_idx       <= '0;
            r_count     <= '0;
            r_max       <= 16'sh8000;
            r_sum       <= '0;
            r_mode      <= '0;
            r_ovalid    <= 1'b0;
        end else begin
            if (w_emit) r_ovalid <= 1'b1;
            else if (i_ready) r_ovalid <= 1'b0;
            unique case (r_state)
                ST_LOAD: begin
                    if (w_in_acc) begin
                        if (r_count == '0) begin
                            r_mode <= {i_derivative, i_func};
                            r_sum  <= '0;
                        end
                        if (r_count < CNT_W'(MAX_LEN)) begin
                            r_count <= r_count + 1'b1;
                            if (i_value > r_max) r_max <= i_value;
                        end
                        if (i_last) begin
                            r_idx       <= '0;
                            r_pass_emit <= (w_func != FN_SOFTMAX);
                            r_state     <= ST_RD;
                        end
                    end
                end
                ST_RD: r_state <= ST_X;
                ST_X: begin
                    r_err <= (w_mfunc == FN_RSVD);
                    if (!r_pass_emit || w_mfunc == FN_SOFTMAX) begin
                        r_state <= ST_MUL;
                    end else if (w_mfunc == FN_SIGMOID) begin
                        r_state <= ST_DIV;
                    end else if (w_mfunc == FN_RELU) begin
                        if (w_mder) r_res <= (r_rdata > 0) ? 32'(ONE_Q16) : 32'd0;
                        else r_res <= (r_rdata > 0) ? {8'd0, r_rdata, 8'd0} : 32'd0;
                        r_state <= ST_OUT;
                    end else begin
                        r_res   <= '0;
                        r_state <= ST_OUT;
                    end
                end
                ST_MUL: begin
                    r_prod  <= 33'(w_diff[15:0]) * 33'(LOG2E_Q16);
                    r_state <= ST_EXP;
                end
                ST_EXP: begin
                    if (r_pass_emit) begin
                        r_state <= ST_DIV;
                    end else begin
                        r_sum <= r_sum + 32'(w_e);
                        if (w_lastidx) begin
                            r_idx       <= '0;
                            r_pass_emit <= 1'b1;
                        end else begin
                            r_idx <= r_idx + 1'b1;
                        end
                        r_state <= ST_RD;
                    end
                end
                ST_DIV: begin
                    if (w_quo_done) begin
                        r_s     <= w_s;
                        r_res   <= 32'(w_s);
                        r_state <= w_mder ? ST_DER : ST_OUT;
                    end
                end
                ST_DER: begin
                    r_res   <= 32'((w_der_p + 34'd32768) >> 16);
                    r_state <= ST_OUT;
                end
                ST_OUT: begin
                    if (!r_ovalid || i_ready) begin
                        if (w_lastidx) begin
                            r_count <= '0;
                            r_max   <= 16'sh8000;
                            r_state <= ST_LOAD;
                        end else begin
                            r_idx   <= r_idx + 1'b1;
                            r_state <= ST_RD;
                        end
                    end
                end
                default: r_state <= ST_LOAD;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_oresult <= r_res;
            r_oerr    <= r_err;
            r_oeov    <= w_lastidx;
        end
    end

    assign o_valid         = r_ovalid;
    assign o_result        = r_oresult;
    assign o_error         = r_oerr;
    assign o_end_of_vector = r_oeov;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_LEN))
        else $error("element count past store depth");

    a_busy_has_elems: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_LOAD) |-> (r_count != '0) && (r_idx < r_count))
        else $error("emit sequencer running without stored elements");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_error) |-> (o_result == 32'sd0))
        else $error("error item carries a nonzero result");
`endif

endmodule

// ===== tb/vector_activation_unit_tb.sv =====
// self-checking testbench for the vector activation unit: random vectors, stalls, predicted results
module vector_activation_unit_tb;
    import vau_pkg::*;

    typedef struct {
        logic [1:0]         func;
        logic               der;
        logic signed [15:0] value;
        logic               last;
    } t_elem;

    typedef struct {
        logic [31:0] result;
        logic        error;
        logic        eov;
    } t_act;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_ready;
    logic [1:0] i_func = '0;
    logic i_derivative = 1'b0;
    logic signed [15:0] i_value = '0;
    logic i_last = 1'b0;
    logic o_valid;
    logic i_ready = 1'b0;
    logic signed [31:0] o_result;
    logic o_error;
    logic o_end_of_vector;

    vector_activation_unit u_top (.*);

    t_elem pending_elems[$];
    t_act  expected_acts[$];
    int    mismatches = 0;
    int    cycles = 0;
    int    send_idle_pct = 0;
    int    recv_idle_pct = 0;
    int    recv_hold = 0;
    bit    hold_request = 0;
    bit    send_pause = 0;
    logic  o_ready_seen = 1'b0;

    // predictor state
    logic signed [15:0] vec_store [MAX_LEN];
    int                 vec_count = 0;
    logic signed [15:0] vec_max = -16'sd32768;
    logic [2:0]         vec_mode = '0;
    logic [31:0]        vec_sum = '0;

    function automatic logic [31:0] exp_of(logic signed [15:0] v, logic signed [15:0] mx);
        logic [63:0] d, y, n;
        d = 64'(32'(int'(mx) - int'(v)));
        y = (d * 64'd94548 + (64'd1 << (EXP_SHIFT - 1))) >> EXP_SHIFT;
        n = y >> EXP_TABLE_BITS;
        if (n >= 32) return 0;
        return 32'(EXP_TABLE[y[EXP_TABLE_BITS-1:0]]) >> n;
    endfunction

    function automatic logic [31:0] slope_of(logic [31:0] s);
        logic [63:0] p;
        p = 64'(s) * 64'(32'd65536 - s);
        return 32'((p + 64'd32768) >> 16);
    endfunction

    function automatic logic [31:0] sigmoid_of(logic signed [15:0] v);
        logic [63:0] mag, den, q;
        mag = (v < 0) ? 64'(-int'(v)) : 64'(int'(v));
        den = 64'd256 + mag;
        q = (mag * 64'd32768 + den / 2) / den;
        return (v < 0) ? 32'(64'd32768 - q) : 32'(64'd32768 + q);
    endfunction

    task automatic predict_activation(t_elem e);
        logic [1:0]  f;
        logic        dflag;
        logic [31:0] r, s;
        t_act        a;
        if (vec_count == 0) begin
            vec_mode = {e.der, e.func};
            vec_sum = '0;
        end
        if (vec_count < MAX_LEN) begin
            vec_store[vec_count] = e.value;
            vec_count++;
            if (e.value > vec_max) vec_max = e.value;
        end
        if (!e.last) return;
        f = vec_mode[1:0];
        dflag = vec_mode[2];
        if (f == FN_SOFTMAX) begin
            vec_sum = '0;
            for (int k = 0; k < vec_count; k++) vec_sum += exp_of(vec_store[k], vec_max);
        end
        for (int k = 0; k < vec_count; k++) begin
            r = '0;
            a.error = 1'b0;
            case (f)
                FN_RELU: begin
                    if (dflag) r = (vec_store[k] > 0) ? 32'd65536 : 0;
                    else r = (vec_store[k] > 0) ? 32'(int'(vec_store[k]) * 256) : 0;
                end
                FN_SIGMOID: begin
                    s = sigmoid_of(vec_store[k]);
                    r = dflag ? slope_of(s) : s;
                end
                FN_SOFTMAX: begin
                    s = 0;
                    if (vec_sum != 0)
                        s = 32'(((64'(exp_of(vec_store[k], vec_max)) << 16)
                                 + 64'(vec_sum / 2)) / 64'(vec_sum));
                    r = dflag ? slope_of(s) : s;
                end
                default: a.error = 1'b1;
            endcase
            a.result = r;
            a.eov = (k + 1 == vec_count);
            expected_acts.push_back(a);
        end
        vec_count = 0;
        vec_max = -16'sd32768;
    endtask

    task automatic queue_vector(int len, logic [1:0] f, logic d, int style);
        t_elem e;
        for (int i = 0; i < len; i++) begin
            e.func = (i == 0) ? f : 2'($urandom_range(0, 3));
            e.der = (i == 0) ? d : 1'($urandom_range(0, 1));
            case (style)
                0: e.value = 16'($urandom);
                1: e.value = 16'sd0 + 16'($urandom_range(0, 1023)) - 16'sd512;
                default: e.value = ($urandom_range(0, 1)) ? 16'sh7fff : 16'sh8000;
            endcase
            e.last = (i == len - 1);
            pending_elems.push_back(e);
        end
    endtask

    task automatic wait_drained();
        while (pending_elems.size() != 0 || expected_acts.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // driver
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if ((!i_valid || o_ready_seen) && pending_elems.size() != 0 && !send_pause
                    && $urandom_range(0, 99) >= send_idle_pct) begin
                i_valid <= 1'b1;
                i_func <= pending_elems[0].func;
                i_derivative <= pending_elems[0].der;
                i_value <= pending_elems[0].value;
                i_last <= pending_elems[0].last;
            end else if (o_ready_seen) begin
                i_valid <= 1'b0;
            end
            if (recv_hold > 0) i_ready <= 1'b0;
            else i_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // acceptance seen at the last rising edge
    always @(posedge i_clk) begin
        o_ready_seen <= 1'b0;
        if (i_rst_n && i_valid && o_ready) begin
            o_ready_seen <= 1'b1;
            predict_activation(pending_elems.pop_front());
        end
    end

    // long receiver hold-off
    always @(posedge i_clk) begin
        if (hold_request && recv_hold == 0) recv_hold <= 300;
        else if (recv_hold > 0) recv_hold <= recv_hold - 1;
    end

    // monitor
    always @(posedge i_clk) begin
        t_act exp_a;
        cycles <= cycles + 1;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_acts.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected item: result %h", o_result);
            end else begin
                exp_a = expected_acts.pop_front();
                if (o_result !== exp_a.result || o_error !== exp_a.error
                        || o_end_of_vector !== exp_a.eov) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %h/%b/%b got %h/%b/%b",
                                 exp_a.result, exp_a.error, exp_a.eov,
                                 o_result, o_error, o_end_of_vector);
                end
            end
        end
        if (cycles > 900000) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        t_elem e;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        // directed: every function and flag, extremes, reserved selector, overflow
        for (int f = 0; f < 4; f++)
            for (int d = 0; d < 2; d++)
                queue_vector(2, 2'(f), 1'(d), 2);
        queue_vector(1, FN_SOFTMAX, 1'b0, 0);
        queue_vector(3, FN_SIGMOID, 1'b1, 1);
        wait_drained();
        // store full: elements past the depth dropped, last still closes
        for (int i = 0; i < MAX_LEN + 3; i++) begin
            e.func = FN_SOFTMAX; e.der = 1'b0; e.value = 16'($urandom);
            e.last = (i == MAX_LEN + 2);
            pending_elems.push_back(e);
        end
        wait_drained();
        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 26 : (phase == 1) ? 57 : 0;
            recv_idle_pct = (phase == 0) ? 57 : (phase == 1) ? 26 : 0;
            for (int n = 0; n < 125;) begin
                int len;
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, MAX_LEN)
                                                  : $urandom_range(1, 6);
                queue_vector(len, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                             $urandom_range(0, 2));
                n += len;
            end
            if (phase == 2) begin
                @(negedge i_clk);
                hold_request = 1;
                @(negedge i_clk);
                hold_request = 0;
            end
            // sender pause until every predicted result has come out
            repeat (200) @(negedge i_clk);
            send_pause = 1;
            while (expected_acts.size() != 0) @(negedge i_clk);
            send_pause = 0;
            wait_drained();
        end
        if (mismatches == 0) $display("RESULT: OK");
        else $display("RESULT: ERROR");
        $finish;
    end
endmodule
